@@ rtl/core/pcl_pkg.sv @@
// Shared types and constants for the positional char list engine.
// Depends on nothing; pcl_mod and the top module refer to it by scoped names.
package pcl_pkg;

    localparam int POS_W     = 16;  // position and end_position
    localparam int DATA_W    = 8;   // element byte
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;
    localparam int FIDX_W    = 6;   // found_index port width
    localparam int LENO_W    = 7;   // length port width
    localparam int DIV_CNT_W = $clog2(POS_W + 1);

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [DATA_W-1:0] byte_t;
    typedef logic [POS_W-1:0]  pos_t;

    localparam cmd_t CMD_INSERT  = 3'd0;
    localparam cmd_t CMD_DELETE  = 3'd1;
    localparam cmd_t CMD_GET     = 3'd2;
    localparam cmd_t CMD_SET     = 3'd3;
    localparam cmd_t CMD_SEARCH  = 3'd4;
    localparam cmd_t CMD_REVERSE = 3'd5;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_BADPOS   = 3'd1;
    localparam status_t ST_FULL     = 3'd2;
    localparam status_t ST_NOTFOUND = 3'd3;
    localparam status_t ST_EMPTY    = 3'd4;

endpackage

@@ rtl/core/pcl_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module pcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/pcl_mod.sv @@
// Iterative remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on pcl_pkg for the dividend width.
module pcl_mod #(
    parameter int DIV_W = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  pcl_pkg::pos_t         dividend,
    input  logic [DIV_W-1:0]      divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      remainder
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [pcl_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]                rem_reg;
    logic [DIV_W-1:0]                dsr_reg;
    pcl_pkg::pos_t                   q_reg;
    logic [DIV_W:0]                  shifted;
    logic [DIV_W:0]                  dsr_ext;

    assign shifted = {rem_reg, q_reg[pcl_pkg::POS_W-1]};
    assign dsr_ext = {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= pcl_pkg::DIV_CNT_W'(pcl_pkg::POS_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - pcl_pkg::DIV_CNT_W'(1);
                if (cnt_reg == pcl_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring step: shift in next dividend bit, subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[pcl_pkg::POS_W-2:0], 1'b0};
            if (shifted >= dsr_ext)
            begin
                rem_reg <= DIV_W'(shifted - dsr_ext);
            end
            else
            begin
                rem_reg <= shifted[DIV_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/positional_char_list_engine_top.sv @@
// Top level of the positional char list engine: sequencer, list length and result beat.
// Depends on pcl_pkg, pcl_ram (element cells) and pcl_mod (remainder for get).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_stall | cmd, position, end_position, data_in
//  out     | output    | out_valid/out_stall | status, data_out, found_index, length
//
// Set and errors finish in the decode state. Insert and delete move each cell between
// the position and the end of the list with a read and then a write; search reads and
// compares one cell at a time up to a match or the end; reverse reads both ends of each
// swap, then writes them back crossed; get waits for the 16-step remainder unit, then
// reads one cell. The cell RAM has a single read port. One command is in work at a time.
// Reset clears the length and the control state; cells hold no defined value until
// written and are never read beyond the length. A waiting result beat holds the
// sequencer in its final state; a new beat is taken while the previous result waits.
module positional_char_list_engine_top #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pcl_pkg::cmd_t                 cmd,
    input  pcl_pkg::pos_t                 position,
    input  pcl_pkg::pos_t                 end_position,
    input  pcl_pkg::byte_t                data_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pcl_pkg::status_t              status,
    output pcl_pkg::byte_t                data_out,
    output logic [pcl_pkg::FIDX_W-1:0]    found_index,
    output logic [pcl_pkg::LENO_W-1:0]    length
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int FIDX_W = pcl_pkg::FIDX_W;
    localparam int LENO_W = pcl_pkg::LENO_W;
    localparam int POS_W  = pcl_pkg::POS_W;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_MV_RD    = 4'd2;
    localparam logic [3:0] S_MV_WR    = 4'd3;
    localparam logic [3:0] S_INS_WR   = 4'd4;
    localparam logic [3:0] S_DEL_CAP  = 4'd5;
    localparam logic [3:0] S_GET_DIV  = 4'd6;
    localparam logic [3:0] S_GET_CAP  = 4'd7;
    localparam logic [3:0] S_SR_RD    = 4'd8;
    localparam logic [3:0] S_SR_CMP   = 4'd9;
    localparam logic [3:0] S_RV_RD_LO = 4'd10;
    localparam logic [3:0] S_RV_RD_HI = 4'd11;
    localparam logic [3:0] S_RV_WR_LO = 4'd12;
    localparam logic [3:0] S_RV_WR_HI = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0]              state_reg, state_next;
    pcl_pkg::cmd_t           cmd_reg;
    pcl_pkg::pos_t           pos_reg;
    pcl_pkg::pos_t           end_reg;
    pcl_pkg::byte_t          din_reg;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [LEN_W-1:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0]       lo_reg, lo_next;
    logic [ADDR_W-1:0]       hi_reg, hi_next;
    pcl_pkg::byte_t          tmp_reg, tmp_next;
    pcl_pkg::status_t        res_stat_reg, res_stat_next;
    pcl_pkg::byte_t          res_dout_reg, res_dout_next;
    logic [LEN_W-1:0]        res_fidx_reg, res_fidx_next;

    logic                    out_valid_reg;
    pcl_pkg::status_t        status_reg;
    pcl_pkg::byte_t          dout_reg;
    logic [FIDX_W-1:0]       fidx_reg;
    logic [LENO_W-1:0]       length_reg;
    logic                    out_load;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    pcl_pkg::byte_t          ram_wdata;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    pcl_pkg::byte_t          ram_rdata;

    logic                    div_start;
    logic                    div_done;
    logic [LEN_W-1:0]        div_rem;

    logic                    in_accept;
    logic [POS_W-1:0]        len_p;
    logic [LEN_W-1:0]        pos_l;
    logic [LEN_W-1:0]        mv_src;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // length and positions compared at the position width; pos_l is used only
    // once the position is known to lie within the list
    assign len_p  = POS_W'(len_reg);
    assign pos_l  = pos_reg[LEN_W-1:0];
    // insert moves each cell up from below, delete pulls each cell down from above
    assign mv_src = (cmd_reg == pcl_pkg::CMD_DELETE) ? idx_reg + LEN_W'(1)
                                                     : idx_reg - LEN_W'(1);

    pcl_ram #(
        .WIDTH (pcl_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pcl_mod #(
        .DIV_W (LEN_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (pos_reg),
        .divisor   (len_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        tmp_next      = tmp_reg;
        res_stat_next = res_stat_reg;
        res_dout_next = res_dout_reg;
        res_fidx_next = res_fidx_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        div_start     = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                // every command starts from a clean result
                res_stat_next = pcl_pkg::ST_OK;
                res_dout_next = '0;
                res_fidx_next = '0;
                state_next    = S_DONE;
                case (cmd_reg)
                    pcl_pkg::CMD_INSERT:
                    begin
                        if (pos_reg > len_p)
                        begin
                            res_stat_next = pcl_pkg::ST_BADPOS;
                        end
                        else if (len_reg == LEN_W'(CAPACITY))
                        begin
                            res_stat_next = pcl_pkg::ST_FULL;
                        end
                        else if (len_p > pos_reg)
                        begin
                            idx_next   = len_reg;
                            state_next = S_MV_RD;
                        end
                        else
                        begin
                            state_next = S_INS_WR;
                        end
                    end
                    pcl_pkg::CMD_DELETE:
                    begin
                        if (pos_reg >= len_p)
                        begin
                            res_stat_next = pcl_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = pos_l[ADDR_W-1:0];
                            state_next = S_DEL_CAP;
                        end
                    end
                    pcl_pkg::CMD_GET:
                    begin
                        if (len_reg == '0)
                        begin
                            res_stat_next = pcl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_GET_DIV;
                        end
                    end
                    pcl_pkg::CMD_SET:
                    begin
                        if (pos_reg >= len_p)
                        begin
                            res_stat_next = pcl_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_l[ADDR_W-1:0];
                            ram_wdata = din_reg;
                        end
                    end
                    pcl_pkg::CMD_SEARCH:
                    begin
                        if (len_reg == '0)
                        begin
                            res_stat_next = pcl_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_SR_RD;
                        end
                    end
                    pcl_pkg::CMD_REVERSE:
                    begin
                        if (end_reg >= len_p)
                        begin
                            res_stat_next = pcl_pkg::ST_BADPOS;
                        end
                        else if (pos_reg < end_reg)
                        begin
                            lo_next    = pos_reg[ADDR_W-1:0];
                            hi_next    = end_reg[ADDR_W-1:0];
                            state_next = S_RV_RD_LO;
                        end
                    end
                    default:
                    begin
                        // unused codes: report ok, change nothing
                    end
                endcase
            end

            S_MV_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = mv_src[ADDR_W-1:0];
                state_next = S_MV_WR;
            end

            S_MV_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                idx_next  = mv_src;
                if (cmd_reg == pcl_pkg::CMD_DELETE)
                begin
                    // length already dropped by one
                    state_next = (mv_src < len_reg) ? S_MV_RD : S_DONE;
                end
                else
                begin
                    state_next = (mv_src > pos_l) ? S_MV_RD : S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_l[ADDR_W-1:0];
                ram_wdata  = din_reg;
                len_next   = len_reg + LEN_W'(1);
                state_next = S_DONE;
            end

            S_DEL_CAP:
            begin
                res_dout_next = ram_rdata;
                len_next      = len_reg - LEN_W'(1);
                idx_next      = pos_l;
                state_next    = ((pos_l + LEN_W'(1)) < len_reg) ? S_MV_RD : S_DONE;
            end

            S_GET_DIV:
            begin
                if (div_done)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = div_rem[ADDR_W-1:0];
                    state_next = S_GET_CAP;
                end
            end

            S_GET_CAP:
            begin
                res_dout_next = ram_rdata;
                state_next    = S_DONE;
            end

            S_SR_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg[ADDR_W-1:0];
                state_next = S_SR_CMP;
            end

            S_SR_CMP:
            begin
                if (ram_rdata == din_reg)
                begin
                    res_fidx_next = idx_reg;
                    state_next    = S_DONE;
                end
                else if ((idx_reg + LEN_W'(1)) < len_reg)
                begin
                    idx_next   = idx_reg + LEN_W'(1);
                    state_next = S_SR_RD;
                end
                else
                begin
                    res_stat_next = pcl_pkg::ST_NOTFOUND;
                    state_next    = S_DONE;
                end
            end

            S_RV_RD_LO:
            begin
                ram_re     = 1'b1;
                ram_raddr  = lo_reg;
                state_next = S_RV_RD_HI;
            end

            S_RV_RD_HI:
            begin
                // low element arrives as the high read goes out
                ram_re     = 1'b1;
                ram_raddr  = hi_reg;
                tmp_next   = ram_rdata;
                state_next = S_RV_WR_LO;
            end

            S_RV_WR_LO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rdata;
                state_next = S_RV_WR_HI;
            end

            S_RV_WR_HI:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hi_reg;
                ram_wdata  = tmp_reg;
                lo_next    = lo_reg + ADDR_W'(1);
                hi_next    = hi_reg - ADDR_W'(1);
                state_next = ((lo_reg + ADDR_W'(1)) < (hi_reg - ADDR_W'(1))) ? S_RV_RD_LO
                                                                             : S_DONE;
            end

            S_DONE:
            begin
                // wait here until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command capture and working values
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= cmd;
            pos_reg <= position;
            end_reg <= end_position;
            din_reg <= data_in;
        end
        idx_reg      <= idx_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        tmp_reg      <= tmp_next;
        res_stat_reg <= res_stat_next;
        res_dout_reg <= res_dout_next;
        res_fidx_reg <= res_fidx_next;
    end

    // result beat register; holds while stalled
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= res_stat_reg;
            dout_reg   <= res_dout_reg;
            fidx_reg   <= FIDX_W'(res_fidx_reg);
            length_reg <= LENO_W'(len_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data_out    = dout_reg;
    assign found_index = fidx_reg;
    assign length      = length_reg;

    // list never grows past its capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    // remainder from the remainder unit always addresses a cell inside the list
    a_rem_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_rem < len_reg))
        else $error("get remainder outside list");

    // a swap pass only starts with the low index below the high index
    a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RV_RD_LO) |-> (lo_reg < hi_reg))
        else $error("reverse indexes crossed");

    // an accepted beat is decoded on the next cycle
    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_DEC))
        else $error("accepted beat not decoded");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for positional_char_list_engine_top: directed and random commands.
// Depends on pcl_pkg and the engine RTL; predicts every result and compares it field by field.
module testbench;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_BEATS = 550;
    localparam int DRAIN_CYCLES = 200;     // longest commands walk the whole list: insert at 0, search, reverse
    localparam int CYCLE_LIMIT  = 600000;
    localparam int FIDX_W       = pcl_pkg::FIDX_W;
    localparam int LENO_W       = pcl_pkg::LENO_W;

    // Codes 6 and 7 carry no name in the package; the engine treats them as no-ops.
    localparam pcl_pkg::cmd_t CMD_SPARE6 = 3'd6;
    localparam pcl_pkg::cmd_t CMD_SPARE7 = 3'd7;

    typedef struct packed {
        pcl_pkg::cmd_t   cmd;
        pcl_pkg::pos_t   pos;
        pcl_pkg::pos_t   endp;
        pcl_pkg::byte_t  data;
    } cmd_beat_t;

    typedef struct packed {
        pcl_pkg::status_t    st;
        pcl_pkg::byte_t      dout;
        logic [FIDX_W-1:0]   fidx;
        logic [LENO_W-1:0]   len;
    } list_result_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    pcl_pkg::cmd_t        cmd = pcl_pkg::CMD_INSERT;
    pcl_pkg::pos_t        position = '0;
    pcl_pkg::pos_t        end_position = '0;
    pcl_pkg::byte_t       data_in = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    pcl_pkg::status_t     status;
    pcl_pkg::byte_t       data_out;
    logic [FIDX_W-1:0]    found_index;
    logic [LENO_W-1:0]    length;

    positional_char_list_engine_top #(.CAPACITY(CAPACITY)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .position     (position),
        .end_position (end_position),
        .data_in      (data_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .data_out     (data_out),
        .found_index  (found_index),
        .length       (length)
    );

    // Commands waiting to be driven, and results the engine still owes us.
    cmd_beat_t      pending_cmds[$];
    list_result_t   owed_results[$];

    // Our own copy of the list; only cells below list_len are ever looked at.
    pcl_pkg::byte_t list_cells[CAPACITY];
    int unsigned    list_len = 0;

    // Length as the stimulus generator sees it, so that it can aim positions.
    int unsigned    gen_len = 0;

    int unsigned    errors = 0;
    int unsigned    cycle_count = 0;

    // Driver bookkeeping: the monitor flags a taken beat, the driver acts on it.
    logic           presenting = 1'b0;
    logic           beat_taken = 1'b0;
    int unsigned    gap_left = 0;
    int unsigned    burst_left = 0;

    // Receiver stall pattern.
    stall_mode_t    stall_mode = STALL_NONE;
    int unsigned    stall_span = 0;
    int unsigned    stall_run = 0;
    logic           stall_on = 1'b0;

    // Apply one command to the list copy and return the result it should report.
    function automatic list_result_t apply_command(cmd_beat_t b);
        list_result_t   r;
        int unsigned    i;
        int unsigned    lo;
        int unsigned    hi;
        pcl_pkg::byte_t t;
        r = '0;
        case (b.cmd)
            pcl_pkg::CMD_INSERT:
                if (b.pos > list_len) r.st = pcl_pkg::ST_BADPOS;
                else if (list_len >= CAPACITY) r.st = pcl_pkg::ST_FULL;
                else
                begin
                    // open a hole at pos by shifting the tail up one cell
                    for (i = list_len; i > b.pos; i--)
                        list_cells[i] = list_cells[i - 1];
                    list_cells[b.pos] = b.data;
                    list_len++;
                end
            pcl_pkg::CMD_DELETE:
                if (b.pos >= list_len) r.st = pcl_pkg::ST_BADPOS;
                else
                begin
                    r.dout = list_cells[b.pos];
                    for (i = b.pos; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i + 1];
                    list_len--;
                end
            pcl_pkg::CMD_GET:
                if (list_len == 0) r.st = pcl_pkg::ST_EMPTY;
                else r.dout = list_cells[b.pos % list_len];
            pcl_pkg::CMD_SET:
                if (b.pos >= list_len) r.st = pcl_pkg::ST_BADPOS;
                else list_cells[b.pos] = b.data;
            pcl_pkg::CMD_SEARCH:
            begin
                r.st = pcl_pkg::ST_NOTFOUND;
                for (i = 0; i < list_len; i++)
                    if (list_cells[i] == b.data)
                    begin
                        r.st   = pcl_pkg::ST_OK;
                        r.fidx = FIDX_W'(i);
                        break;
                    end
            end
            pcl_pkg::CMD_REVERSE:
                if (b.endp >= list_len) r.st = pcl_pkg::ST_BADPOS;
                else
                begin
                    // a start past the end leaves the list as it is
                    lo = b.pos;
                    hi = b.endp;
                    while (lo < hi)
                    begin
                        t              = list_cells[lo];
                        list_cells[lo] = list_cells[hi];
                        list_cells[hi] = t;
                        lo++;
                        hi--;
                    end
                end
            default: ;
        endcase
        r.len = LENO_W'(list_len);
        return r;
    endfunction

    // Queue one command and track the length it leaves behind.
    task automatic queue_beat(pcl_pkg::cmd_t c, pcl_pkg::pos_t p, pcl_pkg::pos_t e,
                              pcl_pkg::byte_t d);
        cmd_beat_t b;
        b.cmd  = c;
        b.pos  = p;
        b.endp = e;
        b.data = d;
        pending_cmds.push_back(b);
        if (c == pcl_pkg::CMD_INSERT && p <= gen_len && gen_len < CAPACITY) gen_len++;
        else if (c == pcl_pkg::CMD_DELETE && p < gen_len) gen_len--;
    endtask

    // Mostly in range, sometimes just past it, now and then any 16-bit value.
    function automatic pcl_pkg::pos_t pick_pos(int unsigned limit);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return pcl_pkg::pos_t'($urandom);
        if (r == 1) return pcl_pkg::pos_t'(limit + 1);
        if (r == 2) return pcl_pkg::pos_t'(limit);
        return pcl_pkg::pos_t'($urandom_range(0, limit));
    endfunction

    // One random command; grow favors inserts, otherwise deletes dominate.
    task automatic queue_random(logic grow);
        int unsigned    r;
        int unsigned    top;
        pcl_pkg::cmd_t  c;
        pcl_pkg::pos_t  p;
        pcl_pkg::pos_t  e;
        pcl_pkg::byte_t d;
        r   = $urandom_range(0, 99);
        top = (gen_len == 0) ? 0 : gen_len - 1;
        // half the bytes come from a tiny alphabet so that searches hit
        d   = ($urandom_range(0, 1) == 1) ? pcl_pkg::byte_t'($urandom)
                                          : pcl_pkg::byte_t'($urandom_range(0, 7));
        p   = pick_pos(top);
        e   = pick_pos(top);
        if (r < (grow ? 50 : 10))
        begin
            c = pcl_pkg::CMD_INSERT;
            p = pick_pos(gen_len);
        end
        else if (r < 60) c = pcl_pkg::CMD_DELETE;
        else if (r < 70)
        begin
            c = pcl_pkg::CMD_GET;
            p = pcl_pkg::pos_t'($urandom);
        end
        else if (r < 78) c = pcl_pkg::CMD_SET;
        else if (r < 88) c = pcl_pkg::CMD_SEARCH;
        else if (r < 96) c = pcl_pkg::CMD_REVERSE;
        else if (r < 98) c = ($urandom_range(0, 1) == 1) ? CMD_SPARE6 : CMD_SPARE7;
        else
        begin
            // noise: any code, any position
            c = pcl_pkg::cmd_t'($urandom_range(0, 7));
            p = pcl_pkg::pos_t'($urandom);
            e = pcl_pkg::pos_t'($urandom);
        end
        queue_beat(c, p, e, d);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Clock: 10 ns period.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Driver: change inputs on the falling edge. Advance to the next beat only after
    // the monitor saw the current one taken; hold the payload while it waits.
    // Work in bursts, dropping valid for a random gap after most bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (beat_taken) presenting = 1'b0;
            beat_taken = 1'b0;
            if (!presenting)
            begin
                if (gap_left > 0) gap_left--;
                else if (pending_cmds.size() > 0)
                begin
                    cmd_beat_t b;
                    b = pending_cmds.pop_front();
                    cmd          <= b.cmd;
                    position     <= b.pos;
                    end_position <= b.endp;
                    data_in      <= b.data;
                    presenting   = 1'b1;
                    if (burst_left > 0) burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        // a third of the bursts run straight into the next one
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            in_valid <= presenting;
        end
    end

    // Receiver: stall on a pattern of its own, picking a new mode after each random span
    // among no stall, random stalls and runs of stall and release.
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            stall_span = $urandom_range(20, 80);
        end
        else stall_span--;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
            default:
            begin
                if (stall_run == 0)
                begin
                    stall_run = $urandom_range(1, 10);
                    stall_on  = ~stall_on;
                end
                stall_run--;
                out_stall <= stall_on;
            end
        endcase
    end

    // Monitor: sample both channels on the rising edge. A result beat is checked
    // against the oldest owed result; a taken command beat is run through the
    // predictor and its result appended to the owed queue.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results owed", $time, owed_results.size());
            $display("FAILED: results differ");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual status %0d",
                             $time, status);
                    $display("    data_out %0d found_index %0d length %0d",
                             data_out, found_index, length);
                end
                else
                begin
                    list_result_t want;
                    want = owed_results.pop_front();
                    check_field("status", 8'(want.st), 8'(status));
                    check_field("data_out", want.dout, data_out);
                    check_field("found_index", 8'(want.fidx), 8'(found_index));
                    check_field("length", 8'(want.len), 8'(length));
                end
            end
            if (in_valid && !in_stall)
            begin
                cmd_beat_t b;
                b.cmd  = cmd;
                b.pos  = position;
                b.endp = end_position;
                b.data = data_in;
                owed_results.push_back(apply_command(b));
                beat_taken = 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic        grow;
        int unsigned extra;

        // Empty list: every access is refused, get reports an empty list.
        queue_beat(pcl_pkg::CMD_GET,     16'hFFFF, 16'h0000, 8'h00);
        queue_beat(pcl_pkg::CMD_DELETE,  16'h0000, 16'h0000, 8'h00);
        queue_beat(pcl_pkg::CMD_SET,     16'h0000, 16'h0000, 8'hFF);
        queue_beat(pcl_pkg::CMD_SEARCH,  16'h0000, 16'h0000, 8'h00);
        queue_beat(pcl_pkg::CMD_REVERSE, 16'h0000, 16'h0000, 8'h00);
        // Insert past the end, then build A5 FF 00 5A with head and tail inserts.
        queue_beat(pcl_pkg::CMD_INSERT,  16'h0001, 16'h0000, 8'h11);
        queue_beat(pcl_pkg::CMD_INSERT,  16'h0000, 16'h0000, 8'hFF);
        queue_beat(pcl_pkg::CMD_INSERT,  16'h0001, 16'h0000, 8'h00);
        queue_beat(pcl_pkg::CMD_INSERT,  16'h0000, 16'h0000, 8'hA5);
        queue_beat(pcl_pkg::CMD_INSERT,  16'h0003, 16'hFFFF, 8'h5A);
        // Get with the largest position wraps modulo the length.
        queue_beat(pcl_pkg::CMD_GET,     16'hFFFF, 16'h0000, 8'h00);
        queue_beat(pcl_pkg::CMD_SET,     16'h0002, 16'h0000, 8'h3C);
        queue_beat(pcl_pkg::CMD_SET,     16'h0004, 16'h0000, 8'h3C);
        queue_beat(pcl_pkg::CMD_SEARCH,  16'h0000, 16'h0000, 8'h3C);
        queue_beat(pcl_pkg::CMD_SEARCH,  16'h0000, 16'h0000, 8'h77);
        // Full reverse, start after end (no-op), end out of range, start far past end.
        queue_beat(pcl_pkg::CMD_REVERSE, 16'h0000, 16'h0003, 8'h00);
        queue_beat(pcl_pkg::CMD_REVERSE, 16'h0003, 16'h0001, 8'h00);
        queue_beat(pcl_pkg::CMD_REVERSE, 16'h0000, 16'h0004, 8'h00);
        queue_beat(pcl_pkg::CMD_REVERSE, 16'hFFFF, 16'h0000, 8'h00);
        queue_beat(pcl_pkg::CMD_DELETE,  16'h0004, 16'h0000, 8'h00);
        queue_beat(pcl_pkg::CMD_DELETE,  16'h0001, 16'h0000, 8'h00);
        queue_beat(pcl_pkg::CMD_GET,     16'h0001, 16'h0000, 8'h00);
        // Unused codes do nothing.
        queue_beat(CMD_SPARE6,           16'hFFFF, 16'hFFFF, 8'hFF);
        queue_beat(CMD_SPARE7,           16'h0000, 16'h0000, 8'h00);

        // Random part: alternate growing the list to full and draining it to empty,
        // lingering a few commands at each end so full and empty cases recur.
        grow  = 1'b1;
        extra = 0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            queue_random(grow);
            if ((grow && gen_len == CAPACITY) || (!grow && gen_len == 0)) extra++;
            if (extra >= 4)
            begin
                grow  = ~grow;
                extra = 0;
            end
        end

        // Hold reset, then release it on a falling edge, away from the rising edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the last command to be taken and its result to come back.
        while (pending_cmds.size() != 0 || presenting || owed_results.size() != 0)
            @(posedge clk);
        // Watch a little longer for stray results.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/pcl_pkg.sv
rtl/core/pcl_ram.sv
rtl/core/pcl_mod.sv
rtl/core/positional_char_list_engine_top.sv
test/testbench.sv
